// File: hw/rtl/povrst_pkg.sv
`default_nettype none

package povrst_pkg;

  localparam int DEF_SECTORS   = 120;
  localparam int DEF_TIME_BITS = 32;

  localparam int NOW_W        = 32;
  localparam int ARM_W        = 7;
  localparam int LAST_W       = 8;
  localparam int QUO_W        = 9;
  localparam int CMP_W        = 32;
  localparam int DEG_PER_TURN = 360;

  localparam int DEBOUNCE_W  = 20;
  localparam int TIMEOUT_W   = 26;
  localparam int GUARD_W     = 24;
  localparam int ANGLE_W     = 9;
  localparam int CFG_DATA_W  = 26;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FORCE_STOP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_READY = 3'd5;

  localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE = DEBOUNCE_W'(50000);
  localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT  = TIMEOUT_W'(1000000);
  localparam logic [GUARD_W-1:0]    RST_GUARD    = GUARD_W'(500000);
  localparam logic [LAST_W-1:0]     LAST_NONE    = 8'hFF;

  localparam logic CMD_PULSE = 1'b0;

  typedef struct packed {
    logic start;
    logic mul_en;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/povrst_muldiv.sv
`default_nettype none

module povrst_muldiv import povrst_pkg::*; #(
  parameter int AW   = DEF_TIME_BITS,
  parameter int MULT = DEF_SECTORS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire md_req_t       req,
  input  wire logic [AW-1:0] a,
  input  wire logic [AW-1:0] d,
  output md_rsp_t            rsp,
  output logic [QUO_W-1:0]   q,
  output logic [AW-1:0]      rem
);

  localparam int MW    = $clog2(MULT + 1);
  localparam int PW    = AW + MW;
  localparam int MIW   = $clog2(MW);
  localparam int CNT_N = (MW > QUO_W) ? MW : QUO_W;
  localparam int CW    = $clog2(CNT_N);
  localparam logic [MW-1:0] MULT_V = MW'(MULT);

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_LOAD = 2'd2;
  localparam logic [1:0] MD_DIV  = 2'd3;

  logic [1:0]       state_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [AW-1:0]    a_r;
  logic [AW-1:0]    d_r;
  logic [PW-1:0]    acc_r;
  logic [PW-1:0]    acc_nxt;
  logic [AW-1:0]    rem_r;
  logic [AW-1:0]    rem_nxt;
  logic [QUO_W-1:0] lo_r;
  logic [QUO_W-1:0] q_r;
  logic [AW:0]      trial;
  logic [AW:0]      trial_sub;
  logic             ge;

  always_comb begin
    acc_nxt   = {acc_r[PW-2:0], 1'b0} + (MULT_V[cnt_r[MIW-1:0]] ? PW'(a_r) : '0);
    trial     = {rem_r, lo_r[QUO_W-1]};
    trial_sub = trial - {1'b0, d_r};
    ge        = trial >= {1'b0, d_r};
    rem_nxt   = ge ? trial_sub[AW-1:0] : trial[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (req.start) begin
            cnt_r   <= CW'(MW - 1);
            state_r <= req.mul_en ? MD_MUL : MD_LOAD;
          end
        end
        MD_MUL: begin
          if (cnt_r == '0) begin
            state_r <= MD_LOAD;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        MD_LOAD: begin
          cnt_r   <= CW'(QUO_W - 1);
          state_r <= MD_DIV;
        end
        MD_DIV: begin
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_r   <= a;
          d_r   <= d;
          acc_r <= req.mul_en ? '0 : PW'(a);
        end
      end
      MD_MUL: acc_r <= acc_nxt;
      MD_LOAD: begin
        rem_r <= AW'(acc_r[PW-1:QUO_W]);
        lo_r  <= acc_r[QUO_W-1:0];
      end
      MD_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[QUO_W-2:0], ge};
        lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign rsp.busy = state_r != MD_IDLE;
  assign rsp.done = done_r;
  assign q        = q_r;
  assign rem      = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/pov_rotation_sector_timer_unit.sv
// A beat's result waits on the shift-add multiply and the restoring divide of the shared serial
// unit only when a sector is computed; otherwise the serial unit is not used for that beat.
// One item at a time; a new beat is taken while the previous result waits at the output.
// Writing the angle offset starts two serial operations that hold off input until both finish.
// Synchronous active-low reset restores register defaults, display on, nothing drawn.
`default_nettype none

module pov_rotation_sector_timer_unit import povrst_pkg::*; #(
  parameter int SECTORS   = DEF_SECTORS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic [NOW_W-1:0]       in_now_us,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_draw,
  output logic [ARM_W-1:0]            out_sector_arm0,
  output logic [ARM_W-1:0]            out_sector_arm1,
  output logic [ARM_W-1:0]            out_sector_arm2,
  output logic [ARM_W-1:0]            out_sector_arm3,
  output logic                        out_display_on,
  output logic                        out_power_off_event,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SW  = $clog2(SECTORS);
  localparam int QTR = SECTORS / 4;
  localparam int TW  = TIME_BITS;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_OFF_MUL = 3'd1;
  localparam logic [2:0] ST_OFF_MOD = 3'd2;
  localparam logic [2:0] ST_PULSE   = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_SECT    = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  logic [2:0]            state_r;
  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [GUARD_W-1:0]    guard_r;
  logic [ANGLE_W-1:0]    angle_r;
  logic                  force_r;
  logic                  frame_r;
  logic [TW-1:0]         lpt_r;
  logic [TW-1:0]         period_r;
  logic [TW-1:0]         pot_r;
  logic                  active_r;
  logic                  rendering_r;
  logic [LAST_W-1:0]     last_drawn_r;
  logic [SW-1:0]         off_mod_r;
  logic                  off_pend_r;
  logic                  out_valid_r;

  logic                  cmd_r;
  logic [TW-1:0]         now_r;
  logic [SW-1:0]         b_r;
  logic                  res_draw_r;
  logic                  res_poff_r;
  logic [SW-1:0]         res_s_r;
  logic                  out_draw_r;
  logic [ARM_W-1:0]      out_arm0_r;
  logic [ARM_W-1:0]      out_arm1_r;
  logic [ARM_W-1:0]      out_arm2_r;
  logic [ARM_W-1:0]      out_arm3_r;
  logic                  out_display_on_r;
  logic                  out_poff_r;

  md_req_t               md_req;
  md_rsp_t               md_rsp;
  logic [TW-1:0]         md_a;
  logic [TW-1:0]         md_d;
  logic [QUO_W-1:0]      md_q;
  logic [TW-1:0]         md_rem;

  logic [TW-1:0]         pulse_diff;
  logic [TW-1:0]         guard_diff;
  logic                  guard_hit;
  logic                  deb_hit;
  logic [TW-1:0]         elapsed;
  logic                  off_cond;
  logic                  sect_cond;
  logic                  clamp;
  logic [SW:0]           sect_sum;
  logic [SW-1:0]         s_sect;
  logic                  draw_hit;
  logic                  load_out;
  logic [SW:0]           arm_sum [4];
  logic [SW-1:0]         arm_v [4];

  always_comb begin
    pulse_diff = now_r - lpt_r;
    guard_diff = now_r - pot_r;
    guard_hit  = CMP_W'(guard_diff) < CMP_W'(guard_r);
    deb_hit    = CMP_W'(pulse_diff) > CMP_W'(debounce_r);
    elapsed    = (lpt_r != '0) ? now_r - lpt_r : '0;
    off_cond   = active_r && (force_r || (CMP_W'(elapsed) > CMP_W'(timeout_r)));
    sect_cond  = frame_r && active_r && !off_cond && (lpt_r != '0) && !force_r &&
                 rendering_r && (period_r != '0);
    clamp      = elapsed >= period_r;
    sect_sum   = {1'b0, b_r} + {1'b0, off_mod_r};
    s_sect     = (sect_sum >= (SW+1)'(SECTORS)) ? SW'(sect_sum - (SW+1)'(SECTORS))
                                                : sect_sum[SW-1:0];
    draw_hit   = LAST_W'(s_sect) != last_drawn_r;
    load_out   = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      arm_sum[k] = {1'b0, res_s_r} + (SW+1)'(k * QTR);
      arm_v[k]   = (arm_sum[k] >= (SW+1)'(SECTORS)) ? SW'(arm_sum[k] - (SW+1)'(SECTORS))
                                                    : arm_sum[k][SW-1:0];
    end
  end

  always_comb begin
    md_req = '0;
    md_a   = '0;
    md_d   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (off_pend_r) begin
          md_req.start  = 1'b1;
          md_req.mul_en = 1'b1;
          md_a          = TW'(angle_r);
          md_d          = TW'(DEG_PER_TURN);
        end
      end
      ST_OFF_MUL: begin
        if (md_rsp.done) begin
          md_req.start = 1'b1;
          md_a         = TW'(md_q);
          md_d         = TW'(SECTORS);
        end
      end
      ST_TICK: begin
        if (sect_cond && !clamp) begin
          md_req.start  = 1'b1;
          md_req.mul_en = 1'b1;
          md_a          = elapsed;
          md_d          = period_r;
        end
      end
      default: ;
    endcase
  end

  povrst_muldiv #(
    .AW   (TW),
    .MULT (SECTORS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (md_a),
    .d     (md_d),
    .rsp   (md_rsp),
    .q     (md_q),
    .rem   (md_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      debounce_r   <= RST_DEBOUNCE;
      timeout_r    <= RST_TIMEOUT;
      guard_r      <= RST_GUARD;
      angle_r      <= '0;
      force_r      <= 1'b0;
      frame_r      <= 1'b0;
      lpt_r        <= '0;
      period_r     <= '0;
      pot_r        <= '0;
      active_r     <= 1'b1;
      rendering_r  <= 1'b0;
      last_drawn_r <= LAST_NONE;
      off_mod_r    <= '0;
      off_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (off_pend_r) begin
            off_pend_r <= 1'b0;
            state_r    <= ST_OFF_MUL;
          end else if (in_valid) begin
            state_r <= ST_PULSE;
          end
        end
        ST_OFF_MUL: begin
          if (md_rsp.done) begin
            state_r <= ST_OFF_MOD;
          end
        end
        ST_OFF_MOD: begin
          if (md_rsp.done) begin
            off_mod_r <= md_rem[SW-1:0];
            state_r   <= ST_IDLE;
          end
        end
        ST_PULSE: begin
          if (cmd_r == CMD_PULSE) begin
            if (!active_r && guard_hit) begin
              state_r <= ST_OUT;
            end else begin
              if (deb_hit) begin
                period_r <= pulse_diff;
                lpt_r    <= now_r;
                if (!force_r) begin
                  if (!active_r) begin
                    active_r    <= 1'b1;
                    rendering_r <= 1'b0;
                  end else begin
                    rendering_r <= 1'b1;
                  end
                end
              end
              state_r <= ST_TICK;
            end
          end else begin
            state_r <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (off_cond) begin
            active_r    <= 1'b0;
            rendering_r <= 1'b0;
            pot_r       <= now_r;
          end
          if (sect_cond) begin
            state_r <= clamp ? ST_SECT : ST_DIV;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (md_rsp.done) begin
            state_r <= ST_SECT;
          end
        end
        ST_SECT: begin
          if (draw_hit) begin
            last_drawn_r <= LAST_W'(s_sect);
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE:    debounce_r <= cfg_wdata[DEBOUNCE_W-1:0];
          REG_TIMEOUT:     timeout_r  <= cfg_wdata[TIMEOUT_W-1:0];
          REG_GUARD:       guard_r    <= cfg_wdata[GUARD_W-1:0];
          REG_ANGLE: begin
            angle_r    <= cfg_wdata[ANGLE_W-1:0];
            off_pend_r <= 1'b1;
          end
          REG_FORCE_STOP:  force_r    <= cfg_wdata[0];
          REG_FRAME_READY: frame_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_r <= in_command;
          now_r <= in_now_us[TW-1:0];
        end
      end
      ST_PULSE: begin
        res_draw_r <= 1'b0;
        res_poff_r <= 1'b0;
      end
      ST_TICK: begin
        res_draw_r <= 1'b0;
        res_poff_r <= off_cond;
        if (clamp) begin
          b_r <= SW'(SECTORS - 1);
        end
      end
      ST_DIV: begin
        if (md_rsp.done) begin
          b_r <= md_q[SW-1:0];
        end
      end
      ST_SECT: begin
        res_draw_r <= draw_hit;
        res_s_r    <= s_sect;
      end
      ST_OUT: begin
        if (load_out) begin
          out_draw_r       <= res_draw_r;
          out_arm0_r       <= res_draw_r ? ARM_W'(arm_v[0]) : '0;
          out_arm1_r       <= res_draw_r ? ARM_W'(arm_v[1]) : '0;
          out_arm2_r       <= res_draw_r ? ARM_W'(arm_v[2]) : '0;
          out_arm3_r       <= res_draw_r ? ARM_W'(arm_v[3]) : '0;
          out_display_on_r <= active_r;
          out_poff_r       <= res_poff_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready            = (state_r == ST_IDLE) && !off_pend_r;
  assign out_valid           = out_valid_r;
  assign out_draw            = out_draw_r;
  assign out_sector_arm0     = out_arm0_r;
  assign out_sector_arm1     = out_arm1_r;
  assign out_sector_arm2     = out_arm2_r;
  assign out_sector_arm3     = out_arm3_r;
  assign out_display_on      = out_display_on_r;
  assign out_power_off_event = out_poff_r;

  a_render_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    rendering_r |-> active_r)
    else $error("rendering set while display is off");

  a_draw_while_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_draw |-> out_display_on && !out_power_off_event)
    else $error("draw beat with display off");

  a_no_draw_zero_arms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_draw |-> (out_sector_arm0 == '0) && (out_sector_arm1 == '0) &&
                                 (out_sector_arm2 == '0) && (out_sector_arm3 == '0))
    else $error("arm sectors nonzero without draw");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> !md_rsp.busy)
    else $error("serial unit started while busy");

  a_accept_to_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_PULSE)
    else $error("accepted beat not taken into processing");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import povrst_pkg::*;

  localparam int          SECT           = DEF_SECTORS;
  localparam int          QUARTER        = SECT / 4;
  localparam logic        CMD_TICK       = ~CMD_PULSE;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_CYCLES    = 90;
  localparam int          HOLD_AT_BEAT   = 250;
  localparam int unsigned DEBOUNCE_MAX   = (1 << DEBOUNCE_W) - 1;
  localparam int unsigned TIMEOUT_MAX    = (1 << TIMEOUT_W) - 1;
  localparam int unsigned GUARD_MAX      = (1 << GUARD_W) - 1;

  typedef struct packed {
    logic             draw;
    logic [ARM_W-1:0] arm0;
    logic [ARM_W-1:0] arm1;
    logic [ARM_W-1:0] arm2;
    logic [ARM_W-1:0] arm3;
    logic             display_on;
    logic             power_off;
  } sector_beat_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   cmd;
    logic [NOW_W-1:0]       now;
    logic                   fixed;
    sector_beat_t           beat;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_command = 1'b0;
  logic [NOW_W-1:0]       in_now_us = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_draw;
  logic [ARM_W-1:0]       out_sector_arm0;
  logic [ARM_W-1:0]       out_sector_arm1;
  logic [ARM_W-1:0]       out_sector_arm2;
  logic [ARM_W-1:0]       out_sector_arm3;
  logic                   out_display_on;
  logic                   out_power_off_event;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic [DEBOUNCE_W-1:0] reg_debounce;
  logic [TIMEOUT_W-1:0]  reg_timeout;
  logic [GUARD_W-1:0]    reg_guard;
  logic [ANGLE_W-1:0]    reg_angle;
  logic                  reg_force_stop;
  logic                  reg_frame_ready;

  logic [NOW_W-1:0]  last_hall_us;
  logic [NOW_W-1:0]  period_us;
  logic [NOW_W-1:0]  off_at_us;
  logic              lit;
  logic              armed;
  logic [LAST_W-1:0] shown_sector;

  sector_beat_t pending_beats[$];
  plan_row_t    plan[$];

  int  errors = 0;
  int  beats_seen = 0;
  int  stuck_cycles = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  src_idle_en = 1'b1;
  bit  snk_idle_en = 1'b1;

  pov_rotation_sector_timer_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_now_us           (in_now_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_draw            (out_draw),
    .out_sector_arm0     (out_sector_arm0),
    .out_sector_arm1     (out_sector_arm1),
    .out_sector_arm2     (out_sector_arm2),
    .out_sector_arm3     (out_sector_arm3),
    .out_display_on      (out_display_on),
    .out_power_off_event (out_power_off_event),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic sector_beat_t quiet_beat(logic on, logic off);
    sector_beat_t b;
    b = '0;
    b.display_on = on;
    b.power_off = off;
    return b;
  endfunction

  function automatic sector_beat_t predict_sector(logic cmd, logic [NOW_W-1:0] now);
    sector_beat_t     b;
    logic [NOW_W-1:0] elapsed;
    logic [63:0]      quo;
    int unsigned      offs;
    int unsigned      s;
    b = '0;
    if (cmd == CMD_PULSE) begin
      if (!lit && (now - off_at_us) < NOW_W'(reg_guard)) begin
        return b;
      end
      if ((now - last_hall_us) > NOW_W'(reg_debounce)) begin
        period_us = now - last_hall_us;
        last_hall_us = now;
        if (!reg_force_stop) begin
          if (!lit) begin
            lit = 1'b1;
            armed = 1'b0;
          end else begin
            armed = 1'b1;
          end
        end
      end
    end
    elapsed = (last_hall_us != '0) ? now - last_hall_us : '0;
    if (lit && (reg_force_stop || elapsed > NOW_W'(reg_timeout))) begin
      lit = 1'b0;
      armed = 1'b0;
      off_at_us = now;
      b.power_off = 1'b1;
    end
    if (reg_frame_ready && lit && last_hall_us != '0 && !reg_force_stop && armed &&
        period_us != '0) begin
      quo = (64'(elapsed) * 64'(SECT)) / 64'(period_us);
      if (quo >= 64'(SECT)) quo = 64'(SECT - 1);
      offs = (int'(reg_angle) * SECT) / DEG_PER_TURN;
      s = (int'(quo[31:0]) + offs) % SECT;
      if (LAST_W'(s) != shown_sector) begin
        shown_sector = LAST_W'(s);
        b.draw = 1'b1;
        b.arm0 = ARM_W'(s);
        b.arm1 = ARM_W'((s + QUARTER) % SECT);
        b.arm2 = ARM_W'((s + 2 * QUARTER) % SECT);
        b.arm3 = ARM_W'((s + 3 * QUARTER) % SECT);
      end
    end
    b.display_on = lit;
    return b;
  endfunction

  function automatic void plan_item(logic cmd, logic [NOW_W-1:0] now, logic fixed,
                                    sector_beat_t beat);
    plan_row_t row;
    row = '0;
    row.cmd = cmd;
    row.now = now;
    row.fixed = fixed;
    row.beat = beat;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic [CFG_INDEX_W-1:0] idx, int unsigned data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = CFG_DATA_W'(data);
    plan.push_back(row);
  endfunction

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:    reg_debounce = val[DEBOUNCE_W-1:0];
      REG_TIMEOUT:     reg_timeout = val[TIMEOUT_W-1:0];
      REG_GUARD:       reg_guard = val[GUARD_W-1:0];
      REG_ANGLE:       reg_angle = val[ANGLE_W-1:0];
      REG_FORCE_STOP:  reg_force_stop = val[0];
      REG_FRAME_READY: reg_frame_ready = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic cmd, logic [NOW_W-1:0] now, logic fixed,
                           sector_beat_t fixed_beat);
    sector_beat_t guess;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_now_us <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = predict_sector(cmd, now);
    pending_beats.push_back(fixed ? fixed_beat : guess);
  endtask

  task automatic run_rotation_phase(int unsigned n_items);
    logic [NOW_W-1:0] cur;
    int unsigned      per, per_j, since, d, div, deb, tmo, grd, ang, r, k;
    drain();
    r = $urandom_range(0, 7);
    deb = (r == 0) ? 0 : (r == 1) ? DEBOUNCE_MAX : $urandom_range(0, 2000);
    per = deb + $urandom_range(1, (r == 1) ? 100000 : 30000);
    r = $urandom_range(0, 7);
    tmo = (r == 0) ? $urandom_range(0, per) : (r == 1) ? TIMEOUT_MAX :
          3 * per + $urandom_range(0, per);
    r = $urandom_range(0, 15);
    grd = (r == 0) ? 0 : (r == 1) ? GUARD_MAX : $urandom_range(0, 3 * per);
    ang = ($urandom_range(0, 7) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(REG_GUARD, CFG_DATA_W'(grd));
    write_reg(REG_FORCE_STOP, CFG_DATA_W'($urandom_range(0, 9) == 0));
    write_reg(REG_FRAME_READY, CFG_DATA_W'($urandom_range(0, 7) != 0));
    write_reg(REG_ANGLE, CFG_DATA_W'(ang));
    r = $urandom_range(0, 2);
    div = (r == 0) ? 10 : (r == 1) ? 60 : 240;
    cur = $urandom;
    since = 0;
    per_j = per;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        d = $urandom_range(1, per / div + 1);
        if (since + d >= per_j) begin
          d = per_j - since;
          cur = cur + d;
          since = 0;
          per_j = per - per / 16 + $urandom_range(0, per / 8);
          send_item(CMD_PULSE, cur, 1'b0, '0);
        end else begin
          cur = cur + d;
          since = since + d;
          send_item(CMD_TICK, cur, 1'b0, '0);
        end
      end else if (r < 86) begin
        send_item(CMD_PULSE, cur + $urandom_range(0, deb / 2 + 10), 1'b0, '0);
      end else if (r < 92) begin
        cur = cur + tmo + $urandom_range(1, 5000);
        since = 0;
        send_item(CMD_TICK, cur, 1'b0, '0);
      end else begin
        send_item(logic'($urandom_range(0, 1)), $urandom, 1'b0, '0);
      end
    end
  endtask

  // The receiver stalls in short bursts and, once, holds off long enough to back up the input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sector_beat_t got;
    sector_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_draw, out_sector_arm0, out_sector_arm1, out_sector_arm2, out_sector_arm3,
             out_display_on, out_power_off_event};
      beats_seen++;
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %h", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("beat %0d mismatch: draw %0d/%0d arms %0d %0d %0d %0d / %0d %0d %0d %0d",
                     beats_seen, want.draw, got.draw, want.arm0, want.arm1, want.arm2,
                     want.arm3, got.arm0, got.arm1, got.arm2, got.arm3);
            $display("  display_on %0d/%0d power_off_event %0d/%0d", want.display_on,
                     got.display_on, want.power_off, got.power_off);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    reg_debounce = RST_DEBOUNCE;
    reg_timeout = RST_TIMEOUT;
    reg_guard = RST_GUARD;
    reg_angle = '0;
    reg_force_stop = 1'b0;
    reg_frame_ready = 1'b0;
    last_hall_us = '0;
    period_us = '0;
    off_at_us = '0;
    lit = 1'b1;
    armed = 1'b0;
    shown_sector = LAST_NONE;

    plan_item(CMD_TICK, 32'd0, 1'b1, quiet_beat(1'b1, 1'b0));
    plan_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, quiet_beat(1'b1, 1'b0));
    plan_item(CMD_PULSE, 32'd100, 1'b1, quiet_beat(1'b1, 1'b0));
    plan_item(CMD_PULSE, 32'd60000, 1'b0, '0);
    plan_cfg(REG_FRAME_READY, 1);
    plan_item(CMD_TICK, 32'd90000, 1'b0, '0);
    plan_item(CMD_TICK, 32'd90000, 1'b0, '0);
    plan_item(CMD_TICK, 32'd260000, 1'b0, '0);
    plan_cfg(REG_ANGLE, 359);
    plan_item(CMD_TICK, 32'd60500, 1'b0, '0);
    plan_cfg(REG_ANGLE, 511);
    plan_item(CMD_TICK, 32'd61000, 1'b0, '0);
    plan_cfg(REG_ANGLE, 0);
    plan_cfg(REG_TIMEOUT, 0);
    plan_item(CMD_TICK, 32'd60001, 1'b1, quiet_beat(1'b0, 1'b1));
    plan_item(CMD_PULSE, 32'd60002, 1'b1, quiet_beat(1'b0, 1'b0));
    plan_cfg(REG_GUARD, 0);
    plan_cfg(REG_DEBOUNCE, 0);
    plan_cfg(REG_TIMEOUT, TIMEOUT_MAX);
    plan_item(CMD_PULSE, 32'd60010, 1'b0, '0);
    plan_item(CMD_PULSE, 32'd60020, 1'b0, '0);
    plan_item(CMD_TICK, 32'd60025, 1'b0, '0);
    plan_item(CMD_TICK, 32'd60029, 1'b0, '0);
    plan_cfg(REG_FORCE_STOP, 1);
    plan_item(CMD_TICK, 32'd60030, 1'b1, quiet_beat(1'b0, 1'b1));
    plan_item(CMD_PULSE, 32'd60040, 1'b0, '0);
    plan_cfg(REG_FORCE_STOP, 0);
    plan_cfg(REG_DEBOUNCE, DEBOUNCE_MAX);
    plan_cfg(REG_GUARD, GUARD_MAX);
    plan_item(CMD_PULSE, 32'd60050, 1'b0, '0);
    plan_item(CMD_PULSE, 32'hFFFF_FF00, 1'b0, '0);
    plan_item(CMD_PULSE, 32'h0010_0000, 1'b0, '0);
    plan_item(CMD_TICK, 32'h0010_0100, 1'b0, '0);
    plan_item(CMD_TICK, 32'h0018_0000, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].cmd, plan[i].now, plan[i].fixed, plan[i].beat);
      end
    end

    // The last two phases run with no idling on either side.
    for (p = 0; p < 12; p++) begin
      src_idle_en = (p < 10);
      snk_idle_en = (p < 10);
      run_rotation_phase(54);
    end

    drain();
    repeat (30) @(posedge clk);
    errors += pending_beats.size();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
